FILE: sv/vlit_pkg.sv
// Shared types and constants for the value live interval table.
package vlit_pkg;

  // Field widths of the stream items
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned VID_W      = 6;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned BOUND_W    = 11;
  localparam int unsigned MASK_W     = 64;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 200;

  // Command queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_DEF   = 2'd0,
    KIND_USE   = 2'd1,
    KIND_EXIT  = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_REPORT = 1'b1
  } back_state_e;

  // One classified command as it travels through the queue
  typedef struct packed {
    kind_e              kind;
    logic               in_range;
    logic [VID_W-1:0]   value_id;
    logic [POS_W-1:0]   position;
  } op_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: sv/vlit_front.sv
// Front end: accepts input beats, decodes them and checks the identifier range.
module vlit_front #(
  parameter int unsigned NUM_VALUES = 64
) (
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [vlit_pkg::IN_DATA_W-1:0] s_axis_tdata,  // value_id[5:0], position[15:6]
  input  logic [vlit_pkg::KIND_W-1:0] s_axis_tuser,   // kind[1:0]
  input  vlit_pkg::fifo_status_t      fifo_status_i,
  output logic                        push_o,
  output vlit_pkg::op_t               op_o
);
  import vlit_pkg::*;

  logic [VID_W-1:0] vid;

  // Take a beat whenever the queue has room
  assign s_axis_tready = !fifo_status_i.full;
  assign push_o        = s_axis_tvalid && !fifo_status_i.full;

  // Decode the beat into a command
  assign vid = s_axis_tdata[VID_W-1:0];

  always_comb begin
    op_o.kind     = kind_e'(s_axis_tuser);
    op_o.value_id = vid;
    op_o.position = s_axis_tdata[VID_W +: POS_W];
    op_o.in_range = (32'(vid) < NUM_VALUES);
  end

endmodule

FILE: sv/vlit_fifo.sv
// Short command queue between the front end and the table back end.
module vlit_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  vlit_pkg::op_t          op_i,
  input  logic                   pop_i,
  output logic                   valid_o,
  output vlit_pkg::op_t          op_o,
  output vlit_pkg::fifo_status_t status_o
);
  import vlit_pkg::*;

  op_t                   mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign status_o.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign valid_o        = !status_o.empty;
  assign op_o           = mem_q[rd_ptr_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue occupancy above depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FIFO_CNT_W'(FIFO_DEPTH)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with occupancy");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue occupancy did not grow on push");
`endif

endmodule

FILE: sv/vlit_back.sv
// Back end: interval table update, parallel mask evaluation and result register.
module vlit_back #(
  parameter int unsigned NUM_VALUES       = 64,
  parameter int unsigned MAX_BLOCK_LENGTH = 1023
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vlit_pkg::LEN_W-1:0]    cfg_wdata_i,
  input  logic                          q_valid_i,
  input  vlit_pkg::op_t                 q_op_i,
  output logic                          q_pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [vlit_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import vlit_pkg::*;

  localparam int unsigned IDX_W = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX =
    (MAX_BLOCK_LENGTH > 1023) ? {LEN_W{1'b1}} : LEN_W'(MAX_BLOCK_LENGTH);

  back_state_e               state_q, state_d;
  logic [LEN_W-1:0]          len_q;
  logic [NUM_VALUES-1:0]     valid_q;
  logic signed [BOUND_W-1:0] start_q [NUM_VALUES];
  logic signed [BOUND_W-1:0] end_q   [NUM_VALUES];
  op_t                       cur_q;
  logic                      out_valid_q;
  logic [OUT_DATA_W-1:0]     out_data_q, out_data_d;

  logic                      out_free;
  logic                      out_load;
  logic                      upd_idx_valid;
  logic [IDX_W-1:0]          upd_idx;
  logic signed [BOUND_W-1:0] upd_pos;
  logic signed [BOUND_W-1:0] upd_len;
  logic signed [BOUND_W-1:0] cur_start;
  logic signed [BOUND_W-1:0] cur_end;
  logic                      cur_valid;
  logic signed [BOUND_W-1:0] new_start;
  logic signed [BOUND_W-1:0] new_end;
  logic                      wr_start;
  logic                      wr_end;
  logic                      wr_en;

  logic [IDX_W-1:0]          rep_idx;
  logic signed [BOUND_W-1:0] rep_pos;
  logic signed [BOUND_W-1:0] rep_len;
  logic [MASK_W-1:0]         entry_m;
  logic [MASK_W-1:0]         exit_m;
  logic [MASK_W-1:0]         live_m;
  logic                      has_v;
  logic                      has_d;

  // Saturate the block length on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= (cfg_wdata_i > LEN_MAX) ? LEN_MAX : cfg_wdata_i;
    end
  end

  // Sequence: pop and update, then report once the result register is free
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = BK_REPORT;
        end
      end
      BK_REPORT: begin
        if (out_free) begin
          out_load = 1'b1;
          q_pop_o  = q_valid_i;
          state_d  = q_valid_i ? BK_REPORT : BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the command being reported
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_op_i;
    end
  end

  // Work out the new bounds of the addressed entry
  assign upd_idx       = q_op_i.value_id[IDX_W-1:0];
  assign upd_idx_valid = q_op_i.in_range;
  assign upd_pos       = signed'({1'b0, q_op_i.position});
  assign upd_len       = signed'({1'b0, len_q});
  assign cur_start     = start_q[upd_idx];
  assign cur_end       = end_q[upd_idx];
  assign cur_valid     = valid_q[upd_idx];

  always_comb begin
    new_start = cur_start;
    new_end   = cur_end;
    wr_start  = 1'b0;
    wr_end    = 1'b0;
    case (q_op_i.kind)
      KIND_DEF: begin
        new_start = upd_pos;
        new_end   = upd_pos;
        wr_start  = 1'b1;
        wr_end    = !cur_valid;
      end
      KIND_USE: begin
        if (cur_valid) begin
          new_start = (upd_pos < cur_start) ? upd_pos : cur_start;
          new_end   = (upd_pos > cur_end) ? upd_pos : cur_end;
        end else begin
          new_start = -11'sd1;
          new_end   = upd_pos;
        end
        wr_start = 1'b1;
        wr_end   = 1'b1;
      end
      KIND_EXIT: begin
        new_start = -11'sd1;
        new_end   = upd_len;
        wr_start  = !cur_valid;
        wr_end    = 1'b1;
      end
      KIND_QUERY: begin
        new_start = cur_start;
        new_end   = cur_end;
      end
      default: begin
        new_start = cur_start;
        new_end   = cur_end;
      end
    endcase
  end

  assign wr_en = q_pop_o && upd_idx_valid;

  // Write the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en && (wr_start || wr_end)) begin
      valid_q[upd_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_start) begin
      start_q[upd_idx] <= new_start;
    end
    if (wr_en && wr_end) begin
      end_q[upd_idx] <= new_end;
    end
  end

  // Evaluate every entry in parallel: entry and exit flags, and liveness at the reported position
  assign rep_idx = cur_q.value_id[IDX_W-1:0];
  assign rep_pos = signed'({1'b0, cur_q.position});
  assign rep_len = signed'({1'b0, len_q});

  always_comb begin
    entry_m = '0;
    exit_m  = '0;
    live_m  = '0;
    for (int i = 0; i < NUM_VALUES; i++) begin
      entry_m[i] = valid_q[i] && start_q[i][BOUND_W-1];
      exit_m[i]  = valid_q[i] && (end_q[i] >= rep_len);
      live_m[i]  = valid_q[i] && (start_q[i] <= rep_pos) && (rep_pos <= end_q[i]);
    end
  end

  assign has_v = cur_q.in_range && valid_q[rep_idx];
  assign has_d = has_v && !start_q[rep_idx][BOUND_W-1];

  always_comb begin
    out_data_d = '0;
    out_data_d[0 +: MASK_W]          = entry_m;
    out_data_d[MASK_W +: MASK_W]     = exit_m;
    out_data_d[2 * MASK_W +: MASK_W] = live_m;
    out_data_d[3 * MASK_W]           = has_v;
    out_data_d[3 * MASK_W + 1]       = has_d;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  a_load_from_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> state_q == BK_REPORT)
    else $error("result loaded outside report state");
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("queue popped while empty");
  a_def_implies_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[3 * MASK_W + 1] && !out_data_q[3 * MASK_W]))
    else $error("definition flag without value flag");
  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (wr_start || wr_end)) |=> valid_q[$past(upd_idx)])
    else $error("table write left entry invalid");
`endif

endmodule

FILE: sv/value_live_interval_table_top.sv
// Path: an accepted beat enters the two-entry command queue; its pop updates the table and
// the command register, which then loads the result register. Throughput: one beat per cycle
// sustained while results are taken; table update and result register overlap across beats.
// The 64-entry interval table updates one entry per cycle and compares all entries at once.
// Reset (rst_ni low, asynchronous): table valid bits, queue, result and block length clear.
// No clearing pass is needed; the block takes beats as soon as reset is released.
module value_live_interval_table_top #(
  parameter int unsigned NUM_VALUES       = 64,
  parameter int unsigned MAX_BLOCK_LENGTH = 1023
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vlit_pkg::LEN_W-1:0]      cfg_wdata_i,     // block_length[9:0]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [vlit_pkg::IN_DATA_W-1:0]  s_axis_tdata,    // value_id[5:0], position[15:6]
  input  logic [vlit_pkg::KIND_W-1:0]     s_axis_tuser,    // kind[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // entry_mask[63:0], exit_mask[127:64], live_mask[191:128], has_value[192],
  // has_definition[193], zero[199:194]
  output logic [vlit_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import vlit_pkg::*;

  fifo_status_t fifo_status;
  logic         push;
  op_t          push_op;
  logic         q_valid;
  op_t          q_op;
  logic         q_pop;

  vlit_front #(
    .NUM_VALUES (NUM_VALUES)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .op_o          (push_op)
  );

  vlit_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .op_i     (push_op),
    .pop_i    (q_pop),
    .valid_o  (q_valid),
    .op_o     (q_op),
    .status_o (fifo_status)
  );

  vlit_back #(
    .NUM_VALUES       (NUM_VALUES),
    .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_op_i        (q_op),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: tb/vlit_liveness_checker.sv
`timescale 1ns / 1ps
// Checker for the live interval table: tracks the intervals and compares every result beat.
module vlit_liveness_checker #(
  parameter int unsigned NUM_VALUES       = 64,
  parameter int unsigned MAX_BLOCK_LENGTH = 1023
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vlit_pkg::LEN_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [vlit_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [vlit_pkg::KIND_W-1:0]     s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [vlit_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              results_seen_o
);
  import vlit_pkg::*;

  localparam logic signed [BOUND_W-1:0] LIVE_IN_START = -1;

  typedef struct packed {
    logic [MASK_W-1:0] entry_mask;
    logic [MASK_W-1:0] exit_mask;
    logic [MASK_W-1:0] live_mask;
    logic              has_value;
    logic              has_definition;
  } liveness_t;

  // Shadow copy of the interval table and the exit position
  logic                      iv_valid [NUM_VALUES];
  logic signed [BOUND_W-1:0] iv_start [NUM_VALUES];
  logic signed [BOUND_W-1:0] iv_end   [NUM_VALUES];
  logic [LEN_W-1:0]          exit_pos;

  liveness_t             liveness_q[$];
  liveness_t             want;
  logic [OUT_DATA_W-1:0] got;
  int                    mismatches   = 0;
  int                    results_seen = 0;

  assign fail_count_o   = mismatches;
  assign results_seen_o = results_seen;

  // Apply one item to the shadow table and build the masks from the state after it
  function automatic liveness_t update_intervals(kind_e kind, logic [VID_W-1:0] vid,
                                                 logic [POS_W-1:0] pos);
    liveness_t                 res;
    logic signed [BOUND_W-1:0] spos;
    logic signed [BOUND_W-1:0] slen;
    int                        v;
    res  = '0;
    spos = $signed({1'b0, pos});
    slen = $signed({1'b0, exit_pos});
    v    = int'(vid);
    if (v < NUM_VALUES) begin
      case (kind)
        KIND_DEF: begin
          // a definition after a use may leave start above end
          if (!iv_valid[v]) iv_end[v] = spos;
          iv_start[v] = spos;
          iv_valid[v] = 1'b1;
        end
        KIND_USE: begin
          if (iv_valid[v]) begin
            if (spos < iv_start[v]) iv_start[v] = spos;
            if (spos > iv_end[v]) iv_end[v] = spos;
          end else begin
            iv_start[v] = LIVE_IN_START;
            iv_end[v]   = spos;
            iv_valid[v] = 1'b1;
          end
        end
        KIND_EXIT: begin
          if (!iv_valid[v]) iv_start[v] = LIVE_IN_START;
          iv_end[v]   = slen;
          iv_valid[v] = 1'b1;
        end
        default: ;
      endcase
      if (iv_valid[v]) begin
        res.has_value      = 1'b1;
        res.has_definition = (iv_start[v] >= 0);
      end
    end
    for (int i = 0; i < NUM_VALUES; i++) begin
      if (iv_valid[i]) begin
        if (iv_start[i] < 0) res.entry_mask[i] = 1'b1;
        if (iv_end[i] >= slen) res.exit_mask[i] = 1'b1;
        if (iv_start[i] <= spos && spos <= iv_end[i]) res.live_mask[i] = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [MASK_W-1:0] seen, logic [MASK_W-1:0] due);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, seen, due);
  endtask

  // Pop and compare result beats, then push predictions for accepted input beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VALUES; i++) begin
        iv_valid[i] = 1'b0;
        iv_start[i] = '0;
        iv_end[i]   = '0;
      end
      exit_pos = '0;
      liveness_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (liveness_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", got[MASK_W-1:0], '0);
        end else begin
          want = liveness_q.pop_front();
          results_seen++;
          if (got[63:0] !== want.entry_mask)
            report_mismatch("entry_mask", got[63:0], want.entry_mask);
          if (got[127:64] !== want.exit_mask)
            report_mismatch("exit_mask", got[127:64], want.exit_mask);
          if (got[191:128] !== want.live_mask)
            report_mismatch("live_mask", got[191:128], want.live_mask);
          if (got[192] !== want.has_value)
            report_mismatch("has_value", MASK_W'(got[192]), MASK_W'(want.has_value));
          if (got[193] !== want.has_definition)
            report_mismatch("has_definition", MASK_W'(got[193]), MASK_W'(want.has_definition));
          if (got[199:194] !== '0)
            report_mismatch("padding", MASK_W'(got[199:194]), '0);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        liveness_q.push_back(update_intervals(kind_e'(s_axis_tuser), s_axis_tdata[VID_W-1:0],
                                              s_axis_tdata[VID_W +: POS_W]));
      // hold the exit position, saturated to the largest block
      if (cfg_we_i) begin
        if (int'(cfg_wdata_i) > MAX_BLOCK_LENGTH) exit_pos = LEN_W'(MAX_BLOCK_LENGTH);
        else exit_pos = cfg_wdata_i;
      end
      pending_o <= liveness_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives the live interval table through its phases and gives the verdict.
module tb_top;
  import vlit_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [LEN_W-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int               fail_count;
  int               pending;
  int               results_seen;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               beats_sent     = 0;
  int               cycle_count    = 0;
  logic [LEN_W-1:0] cur_len        = '0;

  always #5 clk_i = ~clk_i;

  value_live_interval_table_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  vlit_liveness_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_seen_o(results_seen)
  );

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one beat, with random idle cycles ahead of it, and hold it until taken
  task automatic send_beat(kind_e kind, logic [VID_W-1:0] vid, logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {pos, vid};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  // Drop valid and wait until every outstanding result has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_block_length(logic [LEN_W-1:0] len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_len  = len;
  endtask

  // Positions mostly inside the block, sometimes anywhere in the field
  function automatic logic [POS_W-1:0] pick_pos();
    int span;
    span = (cur_len < 16) ? 16 : int'(cur_len);
    if ($urandom_range(99) < 30) return POS_W'($urandom_range(1023));
    return POS_W'($urandom_range(span));
  endfunction

  function automatic logic [POS_W-1:0] pick_after(logic [POS_W-1:0] lo);
    int span;
    int hi;
    span = (cur_len < 16) ? 16 : int'(cur_len);
    hi   = int'(lo) + span;
    if (hi > 1023) hi = 1023;
    return POS_W'($urandom_range(hi, int'(lo)));
  endfunction

  // Mostly def-use lifetimes with random content, the rest live-in values, noise and lone queries
  task automatic run_random(int n);
    int               done;
    int               mode;
    logic [VID_W-1:0] vid;
    logic [POS_W-1:0] p;
    done = 0;
    while (done < n) begin
      mode = $urandom_range(99);
      vid  = VID_W'($urandom_range(63));
      if (mode < 55) begin
        p = pick_pos();
        send_beat(KIND_DEF, vid, p);
        done++;
        repeat ($urandom_range(4, 1)) begin
          send_beat(KIND_USE, vid, pick_after(p));
          done++;
        end
        if ($urandom_range(1) == 1) begin
          send_beat(KIND_EXIT, vid, pick_pos());
          done++;
        end
        send_beat(KIND_QUERY, vid, pick_after(p));
        done++;
      end else if (mode < 70) begin
        // live on entry, then defined somewhere, possibly past its last use
        send_beat(KIND_USE, vid, pick_pos());
        send_beat(KIND_DEF, vid, pick_pos());
        done += 2;
      end else if (mode < 90) begin
        send_beat(kind_e'($urandom_range(3)), vid, POS_W'($urandom_range(1023)));
        done++;
      end else begin
        send_beat(KIND_QUERY, vid, pick_pos());
        done++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, field extremes, every kind, live-in and dead intervals
    set_block_length(LEN_W'(20));
    send_beat(KIND_QUERY, 6'd0, 10'd0);
    send_beat(KIND_DEF, 6'd0, 10'd5);
    send_beat(KIND_USE, 6'd0, 10'd9);
    send_beat(KIND_USE, 6'd0, 10'd2);
    send_beat(KIND_QUERY, 6'd0, 10'd1023);
    send_beat(KIND_USE, 6'd63, 10'd1023);
    send_beat(KIND_EXIT, 6'd1, 10'd0);
    send_beat(KIND_EXIT, 6'd0, 10'd3);
    send_beat(KIND_USE, 6'd2, 10'd7);
    send_beat(KIND_DEF, 6'd2, 10'd12);
    send_beat(KIND_QUERY, 6'd2, 10'd10);
    send_beat(KIND_DEF, 6'd42, 10'd0);
    send_beat(KIND_DEF, 6'd21, 10'd1023);
    send_beat(KIND_QUERY, 6'd21, 10'd1023);
    send_beat(KIND_USE, 6'd21, 10'd0);
    send_beat(KIND_QUERY, 6'd5, 10'd20);
    send_beat(KIND_EXIT, 6'd63, 10'd512);
    send_beat(KIND_DEF, 6'd63, 10'd20);
    send_beat(KIND_QUERY, 6'd63, 10'd20);
    drain();

    // Random phases; the table carries over so stored ends meet a new exit position
    set_block_length(LEN_W'(0));
    run_random(150);
    drain();

    send_idle_pct = 76;
    set_block_length(LEN_W'(1023));
    run_random(150);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 76;
    set_block_length(LEN_W'($urandom_range(1022, 2)));
    run_random(150);
    drain();

    send_idle_pct  = 23;
    recv_stall_pct = 23;
    set_block_length(LEN_W'(1));
    run_random(150);
    drain();

    // let any stray result beat show up
    repeat (8) @(posedge clk_i);
    $display("sent %0d item beats, checked %0d result beats", beats_sent, results_seen);
    $display("block lengths 0, 1, 20, mid and 1023; free flow, sparse sender, slow sink, mixed");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/vlit_pkg.sv
sv/vlit_front.sv
sv/vlit_fifo.sv
sv/vlit_back.sv
sv/value_live_interval_table_top.sv
tb/vlit_liveness_checker.sv
tb/tb_top.sv
